// ----- design/gregorian_day_count_weekday_core_assert.svh -----
// Assertion macros used by the checker of the day count core.
`ifndef GREGORIAN_DAY_COUNT_WEEKDAY_CORE_ASSERT_SVH
`define GREGORIAN_DAY_COUNT_WEEKDAY_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GDCW_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GDCW_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/gdcw_pkg.sv -----
`default_nettype none

package gdcw_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int WD_W    = 3;
    localparam int COUNT_W = 22;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 32;

    // Years above this are clamped.
    localparam logic [YEAR_W-1:0] MAX_YEAR = 14'd9999;

    // floor(q / 25) == (q * 1311) >> 15 holds exactly for q below 4681.
    localparam logic [10:0] RECIP_25  = 11'd1311;
    localparam int          RECIP_SHF = 15;

    localparam logic [8:0] DAYS_PER_YEAR = 9'd365;

    typedef logic [COUNT_W-1:0] day_num_t;

    // Days in the months before month m of a common year. Month zero adds
    // nothing; any month above twelve counts as a whole year.
    function automatic logic [8:0] cum_days(input logic [MONTH_W-1:0] m);
        logic [8:0] r;
        case (m)
            4'd0, 4'd1: r = 9'd0;
            4'd2:       r = 9'd31;
            4'd3:       r = 9'd59;
            4'd4:       r = 9'd90;
            4'd5:       r = 9'd120;
            4'd6:       r = 9'd151;
            4'd7:       r = 9'd181;
            4'd8:       r = 9'd212;
            4'd9:       r = 9'd243;
            4'd10:      r = 9'd273;
            4'd11:      r = 9'd304;
            4'd12:      r = 9'd334;
            default:    r = 9'd365;
        endcase
        return r;
    endfunction

    // Sum of the octal digits; congruent to the value modulo seven.
    function automatic logic [5:0] octal_sum(input day_num_t n);
        logic [23:0] w;
        logic [5:0]  s;
        w = {2'b00, n};
        s = 6'd0;
        for (int k = 0; k < 8; k++)
        begin
            s = s + {3'b000, w[3*k +: 3]};
        end
        return s;
    endfunction

    // Weekday, 1 Monday to 7 Sunday, from a folded octal digit sum.
    function automatic logic [WD_W-1:0] weekday_of_sum(input logic [5:0] s);
        logic [3:0]      t;
        logic [WD_W-1:0] r;
        t = {1'b0, s[5:3]} + {1'b0, s[2:0]};
        case (t)
            4'd1, 4'd8:         r = 3'd1;
            4'd2, 4'd9:         r = 3'd2;
            4'd3, 4'd10:        r = 3'd3;
            4'd4, 4'd11:        r = 3'd4;
            4'd5, 4'd12:        r = 3'd5;
            4'd6, 4'd13:        r = 3'd6;
            default:            r = 3'd7;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- design/gregorian_day_count_weekday_core.sv -----
// Proleptic Gregorian day number and weekday core. Each input item carries a
// start and an end date; for each the core forms the ordinal day number from
// 1 January of year 1, and returns both weekdays (1 Monday to 7 Sunday), the
// number of days from start to end, and a flag with a zero count when the
// start lies after the end. Dates are not checked: a day is added as given,
// month zero adds no month, months above twelve count as a whole year, and
// years above 9999 are clamped. The core is a six-stage pipeline that takes
// one item in every cycle in which the output is not stalled, and a result
// is held in the output register until it is taken. The whole pipeline
// advances together, so the input is ready whenever the output register is
// empty or its item is being taken, and a stall holds every stage in place.
// The second stage holds the 14 by 9 bit multiply for the whole years and
// the reciprocal multiplies for the divisions by one hundred; the later
// stages hold the century test and a wide add, a second wide add, the octal
// digit folding with the comparison, and the weekday lookup.

`default_nettype none

module gregorian_day_count_weekday_core
    import gdcw_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output      logic                   s_axis_tready,
    // first day, first month, first year, second day, second month,
    // second year, pad
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output      logic                   m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // start_weekday, end_weekday, days_between, pad
    output      logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // start_after_end
    output      logic                   m_axis_tuser
);

    localparam int STAGES = 6;

    logic              advance;
    logic [STAGES-1:0] valid_reg;

    // Unpacked input dates, index 0 is the start date, index 1 the end date.
    logic [DAY_W-1:0]   day_in   [2];
    logic [MONTH_W-1:0] month_in [2];
    logic [YEAR_W-1:0]  year_in  [2];

    // Stage 1: clamped year, previous-year count and month offset.
    logic [YEAR_W-1:0]  prev_s1_reg  [2];
    logic [11:0]        quad_s1_reg  [2];
    logic               div4_s1_reg  [2];
    logic [8:0]         mcum_s1_reg  [2];
    logic               mgt2_s1_reg  [2];
    logic [DAY_W-1:0]   day_s1_reg   [2];

    // Stage 2: products.
    day_num_t           base_s2_reg  [2];
    logic [11:0]        pq_s2_reg    [2];
    logic [7:0]         p100_s2_reg  [2];
    logic [11:0]        quad_s2_reg  [2];
    logic [7:0]         q25_s2_reg   [2];
    logic               div4_s2_reg  [2];
    logic [8:0]         mcum_s2_reg  [2];
    logic               mgt2_s2_reg  [2];
    logic [DAY_W-1:0]   day_s2_reg   [2];

    // Stage 3: year part, month and day part, leap flag.
    day_num_t           yrs_s3_reg   [2];
    logic [9:0]         md_s3_reg    [2];
    logic               leapd_s3_reg [2];

    // Stage 4: day numbers.
    day_num_t           num_s4_reg   [2];

    // Stage 5: comparison and octal digit sums.
    logic [5:0]         osum_s5_reg  [2];
    day_num_t           diff_s5_reg;
    logic               after_s5_reg;

    // Stage 6: output register.
    logic [WD_W-1:0]    wd_s6_reg    [2];
    day_num_t           diff_s6_reg;
    logic               after_s6_reg;

    assign advance       = !valid_reg[STAGES-1] || m_axis_tready;
    assign s_axis_tready = advance;
    assign m_axis_tvalid = valid_reg[STAGES-1];

    assign day_in[0]   = s_axis_tdata[4:0];
    assign month_in[0] = s_axis_tdata[8:5];
    assign year_in[0]  = s_axis_tdata[22:9];
    assign day_in[1]   = s_axis_tdata[27:23];
    assign month_in[1] = s_axis_tdata[31:28];
    assign year_in[1]  = s_axis_tdata[45:32];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[STAGES-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge clk)
    begin
        logic [YEAR_W-1:0] ysat;
        logic [22:0]       prod_p;
        logic [22:0]       prod_q;
        logic [22:0]       prod_b;
        logic [12:0]       q25x25;
        logic              cent;
        logic              quadcent;
        logic              leap;
        if (advance)
        begin
            for (int i = 0; i < 2; i++)
            begin
                // Stage 1. Year zero gives a zero previous-year count, which
                // also makes the whole-year term vanish.
                ysat = (year_in[i] > MAX_YEAR) ? MAX_YEAR : year_in[i];
                prev_s1_reg[i] <= (ysat == '0) ? '0 : ysat - 14'd1;
                quad_s1_reg[i] <= ysat[YEAR_W-1:2];
                div4_s1_reg[i] <= (ysat[1:0] == 2'b00);
                mcum_s1_reg[i] <= cum_days(month_in[i]);
                mgt2_s1_reg[i] <= (month_in[i] > 4'd2);
                day_s1_reg[i]  <= day_in[i];

                // Stage 2. Whole years times 365 and the two divisions by 25.
                prod_b = {9'd0, prev_s1_reg[i]} * {14'd0, DAYS_PER_YEAR};
                prod_p = {11'd0, prev_s1_reg[i][YEAR_W-1:2]} * {12'd0, RECIP_25};
                prod_q = {11'd0, quad_s1_reg[i]} * {12'd0, RECIP_25};
                base_s2_reg[i] <= prod_b[COUNT_W-1:0];
                pq_s2_reg[i]   <= prev_s1_reg[i][YEAR_W-1:2];
                p100_s2_reg[i] <= prod_p[RECIP_SHF +: 8];
                quad_s2_reg[i] <= quad_s1_reg[i];
                q25_s2_reg[i]  <= prod_q[RECIP_SHF +: 8];
                div4_s2_reg[i] <= div4_s1_reg[i];
                mcum_s2_reg[i] <= mcum_s1_reg[i];
                mgt2_s2_reg[i] <= mgt2_s1_reg[i];
                day_s2_reg[i]  <= day_s1_reg[i];

                // Stage 3. A year divisible by 4 is a century year when its
                // quarter divides by 25; the year over 100 then tells the
                // fourth centuries apart.
                q25x25   = {5'd0, q25_s2_reg[i]} * 13'd25;
                cent     = div4_s2_reg[i] && (q25x25 == {1'b0, quad_s2_reg[i]});
                quadcent = cent && (q25_s2_reg[i][1:0] == 2'b00);
                leap     = div4_s2_reg[i] && (!cent || quadcent);
                yrs_s3_reg[i] <= base_s2_reg[i] + {10'd0, pq_s2_reg[i]}
                                 - {14'd0, p100_s2_reg[i]}
                                 + {16'd0, p100_s2_reg[i][7:2]};
                md_s3_reg[i]    <= {1'b0, mcum_s2_reg[i]} + {5'd0, day_s2_reg[i]};
                leapd_s3_reg[i] <= leap && mgt2_s2_reg[i];

                // Stage 4.
                num_s4_reg[i] <= yrs_s3_reg[i] + {12'd0, md_s3_reg[i]}
                                 + {21'd0, leapd_s3_reg[i]};

                // Stage 5.
                osum_s5_reg[i] <= octal_sum(num_s4_reg[i]);

                // Stage 6.
                wd_s6_reg[i] <= weekday_of_sum(osum_s5_reg[i]);
            end

            // The span of the supported years fits the count field, so the
            // difference needs no clamping.
            after_s5_reg <= (num_s4_reg[0] > num_s4_reg[1]);
            diff_s5_reg  <= (num_s4_reg[0] > num_s4_reg[1]) ? '0
                            : num_s4_reg[1] - num_s4_reg[0];
            after_s6_reg <= after_s5_reg;
            diff_s6_reg  <= diff_s5_reg;
        end
    end

    assign m_axis_tdata = {4'd0, diff_s6_reg, wd_s6_reg[1], wd_s6_reg[0]};
    assign m_axis_tuser = after_s6_reg;

endmodule

`default_nettype wire

// ----- design/gdcw_checker.sv -----
`default_nettype none

`include "gregorian_day_count_weekday_core_assert.svh"

module gdcw_checker
    import gdcw_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   s_axis_tready,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic                   m_axis_tuser
);

    logic out_stall;
    logic weekdays_ok;
    logic reversed_ok;

    assign out_stall   = m_axis_tvalid && !m_axis_tready;
    assign weekdays_ok = (m_axis_tdata[2:0] != 3'd0) && (m_axis_tdata[5:3] != 3'd0);
    assign reversed_ok = (m_axis_tdata[27:6] == 22'd0) && (m_axis_tdata[31:28] == 4'd0);

    // A waiting result stays offered.
    `GDCW_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, m_axis_tvalid, "result withdrawn")

    // A blocked output stops the input side.
    `GDCW_ASSERT_NOW(a_stall_back, clk, rst_n, out_stall, !s_axis_tready, "taken in stall")

    // Both weekdays lie between Monday and Sunday.
    `GDCW_ASSERT_NOW(a_weekday, clk, rst_n, m_axis_tvalid, weekdays_ok, "bad weekday")

    // Reversed dates give a zero count and the padding stays clear.
    `GDCW_ASSERT_NOW(a_reversed, clk, rst_n, m_axis_tvalid && m_axis_tuser, reversed_ok, "bad count")

endmodule

bind gregorian_day_count_weekday_core gdcw_checker u_gdcw_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
